FILE: rtl/lkv_pkg.sv
package lkv_pkg;

    localparam int CAPACITY  = 8;
    localparam int KEY_BYTES = 8;

    localparam int KEY_W = 64;
    localparam int VAL_W = 32;
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam logic [CNT_W-1:0] CAP_CNT  = CNT_W'(CAPACITY);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

    // Only the low KEY_BYTES bytes of a key take part in matching and storing.
    localparam logic [KEY_W-1:0] KEY_MASK = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
        ((64'd1 << (KEY_BYTES * 8)) - 64'd1);

    localparam logic OP_SET = 1'b0;
    localparam logic OP_GET = 1'b1;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EXISTS = 2'd1;
    localparam logic [1:0] ST_MISS   = 2'd2;

    typedef logic [IDX_W-1:0] idx_t;
    typedef logic [IDX_W-1:0] rank_t;

    typedef struct packed {
        logic              hit;
        idx_t              hit_idx;
        logic [VAL_W-1:0]  hit_val;
        rank_t             hit_rank;
        logic              lru_found;
        idx_t              lru_idx;
        logic              free_found;
        idx_t              free_idx;
    } scan_res_t;

endpackage

FILE: rtl/lkv_ram.sv
module lkv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/lkv_scan.sv
module lkv_scan (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   clr,
    input  logic                                   en,
    input  logic [lkv_pkg::KEY_W-1:0]              key_q,
    input  logic [lkv_pkg::KEY_W-1:0]              key_rdata,
    input  logic [lkv_pkg::VAL_W-1:0]              val_rdata,
    input  logic [lkv_pkg::CAPACITY-1:0]           valid,
    input  lkv_pkg::rank_t [lkv_pkg::CAPACITY-1:0] rank,
    output lkv_pkg::idx_t                          raddr,
    output logic                                   last,
    output lkv_pkg::scan_res_t                     res
);
    import lkv_pkg::*;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             chk_vld_reg, chk_vld_next;
    idx_t             chk_idx_reg, chk_idx_next;
    scan_res_t        res_reg, res_next;
    rank_t            lru_rank_reg, lru_rank_next;

    logic  cell_valid;
    rank_t cell_rank;
    logic  match;

    assign raddr      = cnt_reg[IDX_W-1:0];
    assign cell_valid = valid[chk_idx_reg];
    assign cell_rank  = rank[chk_idx_reg];
    // The one key comparator, applied to a single cell per cycle.
    assign match      = cell_valid && (key_rdata == key_q);
    assign last       = chk_vld_reg && (chk_idx_reg == LAST_IDX);
    assign res        = res_reg;

    always_comb
    begin
        cnt_next      = cnt_reg;
        chk_vld_next  = chk_vld_reg;
        chk_idx_next  = chk_idx_reg;
        res_next      = res_reg;
        lru_rank_next = lru_rank_reg;
        if (clr)
        begin
            cnt_next            = '0;
            chk_vld_next        = 1'b0;
            res_next.hit        = 1'b0;
            res_next.lru_found  = 1'b0;
            res_next.free_found = 1'b0;
        end
        else if (en)
        begin
            chk_vld_next = (cnt_reg != CAP_CNT);
            chk_idx_next = cnt_reg[IDX_W-1:0];
            if (cnt_reg != CAP_CNT)
            begin
                cnt_next = cnt_reg + CNT_W'(1);
            end
            if (chk_vld_reg)
            begin
                if (match && !res_reg.hit)
                begin
                    res_next.hit      = 1'b1;
                    res_next.hit_idx  = chk_idx_reg;
                    res_next.hit_val  = val_rdata;
                    res_next.hit_rank = cell_rank;
                end
                // Ties go to the higher cell, as the cells are scanned upward by index.
                if (cell_valid && (!res_reg.lru_found || cell_rank >= lru_rank_reg))
                begin
                    res_next.lru_found = 1'b1;
                    res_next.lru_idx   = chk_idx_reg;
                    lru_rank_next      = cell_rank;
                end
                if (!cell_valid && !res_reg.free_found)
                begin
                    res_next.free_found = 1'b1;
                    res_next.free_idx   = chk_idx_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            chk_idx_reg  <= '0;
            res_reg      <= '0;
            lru_rank_reg <= '0;
        end
        else
        begin
            cnt_reg      <= cnt_next;
            chk_vld_reg  <= chk_vld_next;
            chk_idx_reg  <= chk_idx_next;
            res_reg      <= res_next;
            lru_rank_reg <= lru_rank_next;
        end
    end

    property p_scan_stops;
        @(posedge clk) disable iff (!rst_n)
        (en && !clr && cnt_reg == CAP_CNT) |=> (cnt_reg == CAP_CNT);
    endproperty
    a_scan_stops: assert property (p_scan_stops)
        else $error("scan counter ran past the last cell");

    property p_hit_holds;
        @(posedge clk) disable iff (!rst_n)
        (res_reg.hit && !clr) |=> (res_reg.hit && $stable(res_reg.hit_idx));
    endproperty
    a_hit_holds: assert property (p_hit_holds)
        else $error("first key match was overwritten during a scan");

    property p_clr_restarts;
        @(posedge clk) disable iff (!rst_n)
        clr |=> (cnt_reg == '0 && !chk_vld_reg && !res_reg.hit);
    endproperty
    a_clr_restarts: assert property (p_clr_restarts)
        else $error("scan did not restart on a new item");

endmodule

FILE: rtl/lru_key_value_cache.sv
// Channel   Signals                            Direction  Transfer when
// command   start, op, key, value / busy       in / out   start && !busy
// result    done, read_value, status, evicted  out        done (one cycle)
//
// After the accepting edge, one shared key comparator visits the cells one per
// cycle through the registered read port of the key/value RAMs; the update
// state S_ACT then applies the update, and the result is registered.
// busy stays high from the accepting edge until the result cycle, so a new
// command is not taken before the result of the last one shows.
// The result shows for one cycle on done; the next command may be taken at the
// edge that ends it.
// Reset clears the valid bits, ranks and occupancy at once: no clearing pass.
// The receiver cannot stall the result.
module lru_key_value_cache (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          op,
    input  logic [lkv_pkg::KEY_W-1:0]     key,
    input  logic signed [lkv_pkg::VAL_W-1:0] value,
    output logic                          done,
    output logic signed [lkv_pkg::VAL_W-1:0] read_value,
    output logic [1:0]                    status,
    output logic                          evicted
);
    import lkv_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_ACT  = 3'b100
    } state_t;

    state_t state_reg, state_next;

    logic                  op_reg;
    logic [KEY_W-1:0]      key_reg;
    logic [VAL_W-1:0]      value_reg;

    logic [CAPACITY-1:0]   valid_reg, valid_next;
    rank_t [CAPACITY-1:0]  rank_reg, rank_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;

    logic                  done_reg, done_next;
    logic [VAL_W-1:0]      rdval_reg, rdval_next;
    logic [1:0]            status_reg, status_next;
    logic                  evict_reg, evict_next;

    logic                  accept;
    logic                  scan_last;
    idx_t                  raddr;
    scan_res_t             res;
    logic [KEY_W-1:0]      key_rdata;
    logic [VAL_W-1:0]      val_rdata;

    logic                  we;
    idx_t                  slot_idx;
    logic                  full;
    logic                  do_evict;
    logic                  do_insert;

    assign accept     = start && (state_reg == S_IDLE);
    assign busy       = (state_reg != S_IDLE);
    assign done       = done_reg;
    assign read_value = rdval_reg;
    assign status     = status_reg;
    assign evicted    = evict_reg;

    lkv_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_key_ram (
        .clk   (clk),
        .we    (we),
        .waddr (slot_idx),
        .wdata (key_reg),
        .raddr (raddr),
        .rdata (key_rdata)
    );

    lkv_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .clk   (clk),
        .we    (we),
        .waddr (slot_idx),
        .wdata (value_reg),
        .raddr (raddr),
        .rdata (val_rdata)
    );

    lkv_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clr       (accept),
        .en        (state_reg == S_SCAN),
        .key_q     (key_reg),
        .key_rdata (key_rdata),
        .val_rdata (val_rdata),
        .valid     (valid_reg),
        .rank      (rank_reg),
        .raddr     (raddr),
        .last      (scan_last),
        .res       (res)
    );

    assign full      = (occ_reg == CAP_CNT);
    assign do_evict  = full && res.lru_found;
    assign do_insert = do_evict || res.free_found;
    assign slot_idx  = do_evict ? res.lru_idx : res.free_idx;
    assign we        = (state_reg == S_ACT) && (op_reg == OP_SET) && !res.hit && do_insert;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_ACT;
                end
            end
            S_ACT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        valid_next  = valid_reg;
        rank_next   = rank_reg;
        occ_next    = occ_reg;
        done_next   = 1'b0;
        rdval_next  = rdval_reg;
        status_next = status_reg;
        evict_next  = evict_reg;
        if (state_reg == S_ACT)
        begin
            done_next   = 1'b1;
            rdval_next  = '0;
            status_next = ST_OK;
            evict_next  = 1'b0;
            if (op_reg == OP_GET)
            begin
                if (!res.hit)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    rdval_next = res.hit_val;
                    // Entries more recent than the hit age by one.
                    for (int i = 0; i < CAPACITY; i++)
                    begin
                        if (valid_reg[i] && rank_reg[i] < res.hit_rank)
                        begin
                            rank_next[i] = rank_reg[i] + rank_t'(1);
                        end
                    end
                    rank_next[res.hit_idx] = '0;
                end
            end
            else if (res.hit)
            begin
                status_next = ST_EXISTS;
            end
            else if (do_insert)
            begin
                evict_next = do_evict;
                for (int i = 0; i < CAPACITY; i++)
                begin
                    if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + rank_t'(1);
                    end
                end
                rank_next[slot_idx]  = '0;
                valid_next[slot_idx] = 1'b1;
                if (!do_evict)
                begin
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            rank_reg  <= '0;
            occ_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            rank_reg  <= rank_next;
            occ_reg   <= occ_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= op;
            key_reg   <= key & KEY_MASK;
            value_reg <= value;
        end
        rdval_reg  <= rdval_next;
        status_reg <= status_next;
        evict_reg  <= evict_next;
    end

    property p_occ_matches_valid;
        @(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == int'(occ_reg);
    endproperty
    a_occ_matches_valid: assert property (p_occ_matches_valid)
        else $error("occupancy disagrees with the valid bits");

    property p_done_after_act;
        @(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_ACT);
    endproperty
    a_done_after_act: assert property (p_done_after_act)
        else $error("result strobe without an update cycle");

    property p_evict_only_when_full;
        @(posedge clk) disable iff (!rst_n)
        (done && evicted) |-> (status == ST_OK && occ_reg == CAP_CNT);
    endproperty
    a_evict_only_when_full: assert property (p_evict_only_when_full)
        else $error("eviction reported while the store had room");

    property p_accept_goes_busy;
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy;
    endproperty
    a_accept_goes_busy: assert property (p_accept_goes_busy)
        else $error("a transfer did not start a scan");

endmodule
